@@ rtl/i2cm_pkg.sv @@
package i2cm_pkg;

    localparam int MAX_BYTES     = 16;
    localparam int TICKS_PER_BIT = 4;
    localparam int TICK_W        = $clog2(TICKS_PER_BIT);
    localparam int BITS_PER_BYTE = 8;
    localparam int LEN_W         = 5;
    localparam int FILL_W        = $clog2(MAX_BYTES + 1);
    localparam int BUF_IDX_W     = $clog2(MAX_BYTES);
    localparam int PHASE_W       = 5;

    localparam logic [TICK_W-1:0] TICK_HALF = TICK_W'(TICKS_PER_BIT / 2);
    localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(TICKS_PER_BIT - 1);

    // item function codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_PUSH  = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;

    // completion status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ADDR_NAK = 2'd1;
    localparam logic [1:0] ST_DATA_NAK = 2'd2;

    // config register indexes
    localparam logic CFG_DEV_ADDR = 1'b0;
    localparam logic CFG_ACK_WAIT = 1'b1;

    // bus sequencer phases; each acknowledge phase follows its send phase
    localparam logic [PHASE_W-1:0] PH_IDLE       = 5'd0;
    localparam logic [PHASE_W-1:0] PH_START      = 5'd1;
    localparam logic [PHASE_W-1:0] PH_ADDR_W     = 5'd2;
    localparam logic [PHASE_W-1:0] PH_ACK_ADDR   = 5'd3;
    localparam logic [PHASE_W-1:0] PH_REG        = 5'd4;
    localparam logic [PHASE_W-1:0] PH_ACK_REG    = 5'd5;
    localparam logic [PHASE_W-1:0] PH_DATA       = 5'd6;
    localparam logic [PHASE_W-1:0] PH_ACK_DATA   = 5'd7;
    localparam logic [PHASE_W-1:0] PH_RESTART    = 5'd8;
    localparam logic [PHASE_W-1:0] PH_ADDR_R     = 5'd9;
    localparam logic [PHASE_W-1:0] PH_ACK_ADDR_R = 5'd10;
    localparam logic [PHASE_W-1:0] PH_RECV       = 5'd11;
    localparam logic [PHASE_W-1:0] PH_MACK       = 5'd12;
    localparam logic [PHASE_W-1:0] PH_STOP       = 5'd13;

    typedef struct packed {
        logic [1:0] status;
        logic       done_res;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       busy_res;
        logic       sda_pull_low;
        logic       scl;
    } result_t;

endpackage

@@ rtl/i2c_master_register_access_core.sv @@
// I2C register-access master. Each input item is one of: a bus tick (func 0, carrying the
// sampled SDA level), a push of one byte into the 16-entry write buffer (func 1, idle only),
// or a transaction start (func 2, idle only) with register address, direction and length.
// Every item gives exactly one result item carrying the SCL and SDA drive levels, the busy
// flag, any received byte and the completion status. A bus bit spans four ticks, SCL low
// for the first two and high for the last two; an acknowledge sampled high on ack_wait_ticks
// ticks (and at least one) aborts the transfer to STOP with a status. The block takes one item per
// clock: the whole sequencer step sits between the state registers and a single result
// register, and a new item is accepted whenever that register is empty or being drained.
// Configuration (device_address at index 0, ack_wait_ticks at index 1) must be written only
// while idle; the block itself does not enforce this.
module i2c_master_register_access_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sda_in[0], reg_addr[8:1], is_read[9], length[14:10], write_byte[22:15], zero pad
    input  logic [23:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // scl[0], sda_pull_low[1], busy_res[2], read_byte[10:3], read_valid[11],
    // done_res[12], status[14:13], zero pad
    output logic [15:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_index,
    input  logic [7:0]  cfg_wr_data
);

    localparam int TW = i2cm_pkg::TICK_W;
    localparam int PW = i2cm_pkg::PHASE_W;
    localparam int LW = i2cm_pkg::LEN_W;
    localparam int FW = i2cm_pkg::FILL_W;
    localparam int IW = i2cm_pkg::BUF_IDX_W;

    logic [1:0]  func;
    logic        sda_in;
    logic [7:0]  reg_addr_in;
    logic        is_read_in;
    logic [LW-1:0] length_in;
    logic [7:0]  write_byte_in;

    assign func          = s_tuser;
    assign sda_in        = s_tdata[0];
    assign reg_addr_in   = s_tdata[8:1];
    assign is_read_in    = s_tdata[9];
    assign length_in     = s_tdata[14:10];
    assign write_byte_in = s_tdata[22:15];

    logic accept;
    assign s_tready = !m_tvalid || m_tready;
    assign accept   = s_tvalid && s_tready;

    // config
    logic [6:0] dev_addr_reg;
    logic [7:0] ack_wait_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= 7'd21;
            ack_wait_reg <= 8'd5;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                i2cm_pkg::CFG_DEV_ADDR: dev_addr_reg <= cfg_wr_data[6:0];
                i2cm_pkg::CFG_ACK_WAIT: ack_wait_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // sequencer state
    logic [PW-1:0] phase_reg, phase_next;
    logic [TW-1:0] tick_reg, tick_next;
    logic [3:0]    bit_cnt_reg, bit_cnt_next;
    logic [LW-1:0] byte_cnt_reg, byte_cnt_next;
    logic [7:0]    shifter_reg, shifter_next;
    logic [7:0]    ack_timer_reg, ack_timer_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [7:0]    req_reg_addr_reg, req_reg_addr_next;
    logic          req_read_reg, req_read_next;
    logic [LW-1:0] req_len_reg, req_len_next;
    logic [1:0]    stop_st_reg, stop_st_next;
    logic          scl_reg, scl_next;
    logic          sda_low_reg, sda_low_next;

    logic [7:0] wbuf [i2cm_pkg::MAX_BYTES];

    i2cm_pkg::result_t res;

    logic          high, at_end;
    logic [3:0]    bit_inc;
    logic [LW-1:0] bc;
    logic [7:0]    timer_inc;
    logic [LW-1:0] len_sat;
    logic          push_ok;

    assign push_ok = accept && func == i2cm_pkg::FUNC_PUSH && phase_reg == i2cm_pkg::PH_IDLE
                     && fill_reg < FW'(i2cm_pkg::MAX_BYTES);

    always_comb begin
        phase_next        = phase_reg;
        tick_next         = tick_reg;
        bit_cnt_next      = bit_cnt_reg;
        byte_cnt_next     = byte_cnt_reg;
        shifter_next      = shifter_reg;
        ack_timer_next    = ack_timer_reg;
        fill_next         = fill_reg;
        req_reg_addr_next = req_reg_addr_reg;
        req_read_next     = req_read_reg;
        req_len_next      = req_len_reg;
        stop_st_next      = stop_st_reg;
        scl_next          = scl_reg;
        sda_low_next      = sda_low_reg;
        res               = '0;

        high      = tick_reg >= i2cm_pkg::TICK_HALF;
        at_end    = tick_reg >= i2cm_pkg::TICK_LAST;
        bit_inc   = bit_cnt_reg + 4'd1;
        bc        = byte_cnt_reg;
        timer_inc = ack_timer_reg;
        len_sat   = length_in;
        if (len_sat == '0) len_sat = LW'(1);
        if (len_sat > LW'(i2cm_pkg::MAX_BYTES)) len_sat = LW'(i2cm_pkg::MAX_BYTES);

        case (func)
            i2cm_pkg::FUNC_TICK: begin
                tick_next = tick_reg + TW'(1);
                unique case (phase_reg)
                    i2cm_pkg::PH_START, i2cm_pkg::PH_RESTART: begin
                        scl_next     = high;
                        sda_low_next = at_end;
                        if (at_end) begin
                            phase_next   = (phase_reg == i2cm_pkg::PH_START) ?
                                           i2cm_pkg::PH_ADDR_W : i2cm_pkg::PH_ADDR_R;
                            shifter_next = {dev_addr_reg,
                                            phase_reg == i2cm_pkg::PH_RESTART};
                            bit_cnt_next = '0;
                            tick_next    = '0;
                        end
                    end
                    i2cm_pkg::PH_ADDR_W, i2cm_pkg::PH_REG, i2cm_pkg::PH_DATA,
                    i2cm_pkg::PH_ADDR_R: begin
                        scl_next     = high;
                        sda_low_next = !shifter_reg[7];
                        if (at_end) begin
                            shifter_next = {shifter_reg[6:0], 1'b0};
                            bit_cnt_next = bit_inc;
                            tick_next    = '0;
                            if (bit_inc >= 4'(i2cm_pkg::BITS_PER_BYTE)) begin
                                bit_cnt_next   = '0;
                                ack_timer_next = '0;
                                phase_next     = phase_reg + PW'(1);
                            end
                        end
                    end
                    i2cm_pkg::PH_ACK_ADDR, i2cm_pkg::PH_ACK_REG, i2cm_pkg::PH_ACK_DATA,
                    i2cm_pkg::PH_ACK_ADDR_R: begin
                        sda_low_next = 1'b0;
                        scl_next     = high;
                        if (high) begin
                            if (!sda_in) begin
                                tick_next = '0;
                                bit_cnt_next = '0;
                                unique case (phase_reg)
                                    i2cm_pkg::PH_ACK_ADDR: begin
                                        phase_next   = i2cm_pkg::PH_REG;
                                        shifter_next = req_reg_addr_reg;
                                    end
                                    i2cm_pkg::PH_ACK_REG, i2cm_pkg::PH_ACK_DATA: begin
                                        if (phase_reg == i2cm_pkg::PH_ACK_REG && req_read_reg)
                                        begin
                                            phase_next   = i2cm_pkg::PH_RESTART;
                                            bit_cnt_next = bit_cnt_reg;
                                        end else begin
                                            bc = (phase_reg == i2cm_pkg::PH_ACK_REG) ? '0 :
                                                 byte_cnt_reg + LW'(1);
                                            byte_cnt_next = bc;
                                            if (bc < req_len_reg &&
                                                bc < LW'(i2cm_pkg::MAX_BYTES)) begin
                                                phase_next   = i2cm_pkg::PH_DATA;
                                                shifter_next = wbuf[bc[IW-1:0]];
                                            end else begin
                                                phase_next   = i2cm_pkg::PH_STOP;
                                                stop_st_next = i2cm_pkg::ST_OK;
                                                bit_cnt_next = bit_cnt_reg;
                                            end
                                        end
                                    end
                                    default: begin
                                        byte_cnt_next = '0;
                                        phase_next    = i2cm_pkg::PH_RECV;
                                        shifter_next  = '0;
                                    end
                                endcase
                            end else begin
                                if (ack_timer_reg != 8'hFF) timer_inc = ack_timer_reg + 8'd1;
                                ack_timer_next = timer_inc;
                                if (timer_inc >= ack_wait_reg) begin
                                    phase_next   = i2cm_pkg::PH_STOP;
                                    tick_next    = '0;
                                    stop_st_next = (phase_reg == i2cm_pkg::PH_ACK_ADDR) ?
                                                   i2cm_pkg::ST_ADDR_NAK :
                                                   i2cm_pkg::ST_DATA_NAK;
                                end else if (at_end) begin
                                    tick_next = tick_reg;   // stretch SCL high
                                end
                            end
                        end
                    end
                    i2cm_pkg::PH_RECV: begin
                        scl_next     = high;
                        sda_low_next = 1'b0;
                        if (at_end) begin
                            shifter_next = {shifter_reg[6:0], sda_in};
                            bit_cnt_next = bit_inc;
                            tick_next    = '0;
                            if (bit_inc >= 4'(i2cm_pkg::BITS_PER_BYTE)) begin
                                res.read_byte  = {shifter_reg[6:0], sda_in};
                                res.read_valid = 1'b1;
                                byte_cnt_next  = byte_cnt_reg + LW'(1);
                                bit_cnt_next   = '0;
                                phase_next     = i2cm_pkg::PH_MACK;
                            end
                        end
                    end
                    i2cm_pkg::PH_MACK: begin
                        scl_next     = high;
                        sda_low_next = byte_cnt_reg < req_len_reg;
                        if (at_end) begin
                            tick_next = '0;
                            if (byte_cnt_reg < req_len_reg) begin
                                phase_next   = i2cm_pkg::PH_RECV;
                                shifter_next = '0;
                                bit_cnt_next = '0;
                            end else begin
                                phase_next   = i2cm_pkg::PH_STOP;
                                stop_st_next = i2cm_pkg::ST_OK;
                            end
                        end
                    end
                    i2cm_pkg::PH_STOP: begin
                        scl_next     = high;
                        sda_low_next = !at_end;
                        if (at_end) begin
                            res.done_res = 1'b1;
                            res.status   = stop_st_reg;
                            phase_next   = i2cm_pkg::PH_IDLE;
                            tick_next    = '0;
                        end
                    end
                    default: begin
                        phase_next   = i2cm_pkg::PH_IDLE;
                        scl_next     = 1'b1;
                        sda_low_next = 1'b0;
                        tick_next    = '0;
                    end
                endcase
            end
            i2cm_pkg::FUNC_PUSH: begin
                if (push_ok) fill_next = fill_reg + FW'(1);
            end
            i2cm_pkg::FUNC_START: begin
                if (phase_reg == i2cm_pkg::PH_IDLE) begin
                    req_reg_addr_next = reg_addr_in;
                    req_read_next     = is_read_in;
                    req_len_next      = len_sat;
                    phase_next        = i2cm_pkg::PH_START;
                    tick_next         = '0;
                    bit_cnt_next      = '0;
                    byte_cnt_next     = '0;
                    ack_timer_next    = '0;
                    stop_st_next      = i2cm_pkg::ST_OK;
                    fill_next         = '0;
                end
            end
            default: ;
        endcase

        res.scl          = scl_next;
        res.sda_pull_low = sda_low_next;
        res.busy_res     = phase_next != i2cm_pkg::PH_IDLE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= i2cm_pkg::PH_IDLE;
            tick_reg         <= '0;
            bit_cnt_reg      <= '0;
            byte_cnt_reg     <= '0;
            shifter_reg      <= '0;
            ack_timer_reg    <= '0;
            fill_reg         <= '0;
            req_reg_addr_reg <= '0;
            req_read_reg     <= 1'b0;
            req_len_reg      <= '0;
            stop_st_reg      <= i2cm_pkg::ST_OK;
            scl_reg          <= 1'b1;
            sda_low_reg      <= 1'b0;
        end else if (accept) begin
            phase_reg        <= phase_next;
            tick_reg         <= tick_next;
            bit_cnt_reg      <= bit_cnt_next;
            byte_cnt_reg     <= byte_cnt_next;
            shifter_reg      <= shifter_next;
            ack_timer_reg    <= ack_timer_next;
            fill_reg         <= fill_next;
            req_reg_addr_reg <= req_reg_addr_next;
            req_read_reg     <= req_read_next;
            req_len_reg      <= req_len_next;
            stop_st_reg      <= stop_st_next;
            scl_reg          <= scl_next;
            sda_low_reg      <= sda_low_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ok) wbuf[fill_reg[IW-1:0]] <= write_byte_in;
    end

    // result register
    logic            m_tvalid_reg;
    i2cm_pkg::result_t res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) res_reg <= res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, res_reg};

    // a non-tick item never moves the bus lines
    a_lines_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && func != i2cm_pkg::FUNC_TICK |=>
            scl_reg == $past(scl_reg) && sda_low_reg == $past(sda_low_reg))
        else $error("bus lines changed on a non-tick item");

    a_status_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !res_reg.done_res |-> res_reg.status == i2cm_pkg::ST_OK)
        else $error("status reported without completion");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(i2cm_pkg::MAX_BYTES))
        else $error("write buffer overfilled");

    a_rvalid_recv: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res.read_valid |=> phase_reg == i2cm_pkg::PH_MACK)
        else $error("read byte outside receive phase");

endmodule

@@ sim/tb_i2c_master_register_access_core.sv @@
module tb_i2c_master_register_access_core;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    localparam logic [1:0] FUNC_NONE = 2'd3;   // unused code, must be ignored
    localparam int NO_NAK = -1;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // sda_in[0], reg_addr[8:1], is_read[9], length[14:10], write_byte[22:15], zero pad
    logic [23:0] s_tdata = '0;
    // func[1:0]
    logic [1:0]  s_tuser = FUNC_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // scl[0], sda_pull_low[1], busy_res[2], read_byte[10:3], read_valid[11],
    // done_res[12], status[14:13], zero pad
    logic [15:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_index = CFG_DEV_ADDR;
    logic [7:0]  cfg_wr_data = '0;

    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int errors = 0;

    // mirror of the bus sequencer
    logic [6:0]         dev_addr = 7'd21;
    logic [7:0]         ack_limit = 8'd5;
    logic [PHASE_W-1:0] bus_phase = PH_IDLE;
    logic [TICK_W-1:0]  quarter = '0;
    logic [3:0]         bit_idx = '0;
    logic [4:0]         byte_idx = '0;
    logic [7:0]         shifter = '0;
    logic [7:0]         ack_ticks = '0;
    logic [7:0]         tx_buf [MAX_BYTES] = '{default: '0};
    logic [4:0]         tx_fill = '0;
    int                 tx_written = 0;   // entries filled at least once since reset
    logic [7:0]         req_reg = '0;
    logic               req_rd = 1'b0;
    logic [4:0]         req_len = '0;
    logic [1:0]         end_status = ST_OK;
    logic               drv_scl = 1'b1;
    logic               drv_sda_low = 1'b0;

    result_t bus_result_q[$];

    i2c_master_register_access_core i_dut (.*);

    initial forever #2 aclk = ~aclk;

    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic rbit();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    function automatic void load_byte(input logic [PHASE_W-1:0] nxt, input logic [7:0] b);
        bus_phase = nxt;
        shifter   = b;
        bit_idx   = '0;
        quarter   = '0;
    endfunction

    function automatic void go_stop(input logic [1:0] st);
        end_status = st;
        bus_phase  = PH_STOP;
        quarter    = '0;
    endfunction

    function automatic void next_data_or_stop();
        if (byte_idx < req_len && byte_idx < MAX_BYTES)
            load_byte(PH_DATA, tx_buf[byte_idx[3:0]]);
        else
            go_stop(ST_OK);
    endfunction

    function automatic result_t step_master(input logic [1:0] fn, input logic sda,
                                            input logic [7:0] ra, input logic rd,
                                            input logic [4:0] len, input logic [7:0] wb);
        result_t r;
        logic hi, last, adv;
        logic [4:0] l;
        r = '0;
        if (fn == FUNC_TICK) begin
            hi   = quarter >= TICK_HALF;
            last = quarter >= TICK_LAST;
            adv  = 1'b1;
            case (bus_phase)
                PH_START, PH_RESTART: begin
                    drv_scl     = hi;
                    drv_sda_low = last;
                    if (last) begin
                        load_byte(bus_phase == PH_START ? PH_ADDR_W : PH_ADDR_R,
                                  {dev_addr, bus_phase != PH_START});
                        adv = 1'b0;
                    end
                end
                PH_ADDR_W, PH_REG, PH_DATA, PH_ADDR_R: begin
                    drv_scl     = hi;
                    drv_sda_low = !shifter[7];
                    if (last) begin
                        shifter = shifter << 1;
                        quarter = '0;
                        adv     = 1'b0;
                        if (bit_idx == 4'd7) begin
                            bit_idx   = '0;
                            ack_ticks = '0;
                            bus_phase = bus_phase + 5'd1;   // matching acknowledge
                        end else begin
                            bit_idx = bit_idx + 4'd1;
                        end
                    end
                end
                PH_ACK_ADDR, PH_ACK_REG, PH_ACK_DATA, PH_ACK_ADDR_R: begin
                    drv_sda_low = 1'b0;
                    drv_scl     = hi;
                    if (hi) begin
                        adv = 1'b0;
                        if (!sda) begin
                            case (bus_phase)
                                PH_ACK_ADDR: load_byte(PH_REG, req_reg);
                                PH_ACK_REG: begin
                                    if (req_rd) begin
                                        bus_phase = PH_RESTART;
                                        quarter   = '0;
                                    end else begin
                                        byte_idx = '0;
                                        next_data_or_stop();
                                    end
                                end
                                PH_ACK_DATA: begin
                                    byte_idx = byte_idx + 5'd1;
                                    next_data_or_stop();
                                end
                                default: begin
                                    byte_idx = '0;
                                    load_byte(PH_RECV, 8'h00);
                                end
                            endcase
                        end else begin
                            if (ack_ticks != 8'hFF) ack_ticks = ack_ticks + 8'd1;
                            if (ack_ticks >= ack_limit)
                                go_stop(bus_phase == PH_ACK_ADDR ? ST_ADDR_NAK : ST_DATA_NAK);
                            else if (!last)
                                adv = 1'b1;   // on the last quarter SCL is held high
                        end
                    end
                end
                PH_RECV: begin
                    drv_scl     = hi;
                    drv_sda_low = 1'b0;
                    if (last) begin
                        shifter = {shifter[6:0], sda};
                        quarter = '0;
                        adv     = 1'b0;
                        if (bit_idx == 4'd7) begin
                            r.read_byte  = shifter;
                            r.read_valid = 1'b1;
                            byte_idx     = byte_idx + 5'd1;
                            bit_idx      = '0;
                            bus_phase    = PH_MACK;
                        end else begin
                            bit_idx = bit_idx + 4'd1;
                        end
                    end
                end
                PH_MACK: begin
                    drv_scl     = hi;
                    drv_sda_low = byte_idx < req_len;
                    if (last) begin
                        adv = 1'b0;
                        if (byte_idx < req_len) load_byte(PH_RECV, 8'h00);
                        else go_stop(ST_OK);
                    end
                end
                PH_STOP: begin
                    drv_scl     = hi;
                    drv_sda_low = !last;
                    if (last) begin
                        r.done_res = 1'b1;
                        r.status   = end_status;
                        bus_phase  = PH_IDLE;
                        quarter    = '0;
                        adv        = 1'b0;
                    end
                end
                default: begin
                    bus_phase   = PH_IDLE;
                    drv_scl     = 1'b1;
                    drv_sda_low = 1'b0;
                    quarter     = '0;
                    adv         = 1'b0;
                end
            endcase
            if (adv) quarter = quarter + 1'b1;
        end else if (fn == FUNC_PUSH) begin
            if (bus_phase == PH_IDLE && tx_fill < MAX_BYTES) begin
                tx_buf[tx_fill[3:0]] = wb;
                tx_fill = tx_fill + 5'd1;
                if (tx_fill > tx_written) tx_written = tx_fill;
            end
        end else if (fn == FUNC_START) begin
            if (bus_phase == PH_IDLE) begin
                l = (len == 5'd0) ? 5'd1 : (len > MAX_BYTES) ? 5'(MAX_BYTES) : len;
                req_reg    = ra;
                req_rd     = rd;
                req_len    = l;
                bus_phase  = PH_START;
                quarter    = '0;
                bit_idx    = '0;
                byte_idx   = '0;
                ack_ticks  = '0;
                end_status = ST_OK;
                tx_fill    = '0;
            end
        end
        r.scl          = drv_scl;
        r.sda_pull_low = drv_sda_low;
        r.busy_res     = bus_phase != PH_IDLE;
        return r;
    endfunction

    // what the addressed target puts on SDA for the next tick
    function automatic logic target_sda(input int nak_ack, input int hold);
        int ack_no;
        case (bus_phase)
            PH_ACK_ADDR:   ack_no = 0;
            PH_ACK_REG:    ack_no = 1;
            PH_ACK_ADDR_R: ack_no = 2;
            PH_ACK_DATA:   ack_no = 2 + int'(byte_idx);
            default:       return rbit();
        endcase
        if (quarter < TICK_HALF) return rbit();
        if (ack_no == nak_ack) return 1'b1;
        return ack_ticks < hold;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        result_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            if (bus_result_q.size() == 0) begin
                $error("result item with nothing outstanding: %h", m_tdata);
                errors++;
            end else begin
                want = bus_result_q.pop_front();
                got  = result_t'(m_tdata[$bits(result_t)-1:0]);
                check_field("scl", want.scl, got.scl);
                check_field("sda_pull_low", want.sda_pull_low, got.sda_pull_low);
                check_field("busy_res", want.busy_res, got.busy_res);
                check_field("read_byte", want.read_byte, got.read_byte);
                check_field("read_valid", want.read_valid, got.read_valid);
                check_field("done_res", want.done_res, got.done_res);
                check_field("status", want.status, got.status);
            end
        end
    end

    task automatic send_item(input logic [1:0] fn, input logic sda, input logic [7:0] ra,
                             input logic rd, input logic [4:0] len, input logic [7:0] wb);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {1'b0, wb, len, rd, ra, sda};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bus_result_q.push_back(step_master(fn, sda, ra, rd, len, wb));
        items_sent++;
    endtask

    task automatic set_config(input logic [6:0] addr, input logic [7:0] wait_ticks);
        // only touch the registers once the bus is quiet and every result is back
        s_tvalid <= 1'b0;
        while (bus_result_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= CFG_DEV_ADDR;
        cfg_wr_data  <= {1'b0, addr};
        @(posedge aclk);
        cfg_wr_index <= CFG_ACK_WAIT;
        cfg_wr_data  <= wait_ticks;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        dev_addr  = addr;
        ack_limit = wait_ticks;
    endtask

    // one start item and then ticks, mixed with random stray items, until the bus is back at idle
    task automatic run_transfer(input logic [7:0] ra, input logic rd, input logic [4:0] len,
                                input int nak_ack, input int hold, input int noise_pct);
        logic [4:0] eff;
        logic [1:0] fn;
        eff = (len == 5'd0) ? 5'd1 : (len > MAX_BYTES) ? 5'(MAX_BYTES) : len;
        // a write must not reach buffer entries that were never filled
        if (!rd && eff > tx_written) rd = 1'b1;
        send_item(FUNC_START, rbit(), ra, rd, len, rnd8());
        while (bus_phase != PH_IDLE) begin
            if ($urandom_range(99) < noise_pct) begin
                case ($urandom_range(2))
                    0:       fn = FUNC_PUSH;
                    1:       fn = FUNC_START;
                    default: fn = FUNC_NONE;
                endcase
                send_item(fn, rbit(), rnd8(), rbit(), 5'($urandom), rnd8());
            end else begin
                send_item(FUNC_TICK, target_sda(nak_ack, hold), rnd8(), rbit(),
                          5'($urandom), rnd8());
            end
        end
    endtask

    task automatic test_buffered_write();
        logic [7:0] fixed [6] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};
        foreach (fixed[i]) send_item(FUNC_PUSH, rbit(), rnd8(), rbit(), 5'($urandom), fixed[i]);
        repeat (10) send_item(FUNC_PUSH, rbit(), rnd8(), rbit(), 5'($urandom), rnd8());
        // buffer already full: dropped
        send_item(FUNC_PUSH, rbit(), rnd8(), rbit(), 5'($urandom), 8'h3C);
        run_transfer(8'hFF, 1'b0, 5'd0, NO_NAK, 0, 0);
        run_transfer(8'h00, 1'b0, 5'd4, NO_NAK, 1, 0);
    endtask

    task automatic test_long_read();
        set_config(7'h7F, 8'd255);
        // length beyond the buffer size saturates, acks stretched each time
        run_transfer(8'hA5, 1'b1, 5'd31, NO_NAK, 3, 0);
    endtask

    task automatic test_zero_ack_limit();
        set_config(7'h00, 8'd0);
        run_transfer(8'h5A, 1'b0, 5'd1, 0, 0, 0);
        run_transfer(8'h3C, 1'b1, 5'd2, NO_NAK, 0, 0);
    endtask

    task automatic test_late_nak();
        set_config(7'h2A, 8'd3);
        run_transfer(8'h11, 1'b0, 5'd3, 3, 0, 0);
        run_transfer(8'h22, 1'b1, 5'd2, 2, 0, 0);
        run_transfer(8'h33, 1'b1, 5'd1, NO_NAK, 2, 0);
        run_transfer(8'h44, 1'b0, 5'd1, NO_NAK, 3, 0);
    endtask

    task automatic test_stray_items();
        send_item(FUNC_NONE, 1'b1, 8'hFF, 1'b1, 5'd31, 8'hFF);
        send_item(FUNC_TICK, 1'b0, 8'h00, 1'b0, 5'd0, 8'h00);
        send_item(FUNC_TICK, 1'b1, 8'hFF, 1'b1, 5'd17, 8'hFF);
        run_transfer(8'h81, 1'b0, 5'd2, NO_NAK, 0, 40);
    endtask

    task automatic random_transfer();
        int n, pick;
        logic [4:0] len;
        n = ($urandom_range(9) == 0) ? 17 : $urandom_range(4);
        repeat (n) send_item(FUNC_PUSH, rbit(), rnd8(), rbit(), 5'($urandom), rnd8());
        pick = $urandom_range(99);
        len  = (pick < 60) ? 5'($urandom_range(2)) :
               (pick < 90) ? 5'($urandom_range(3, 6)) : 5'($urandom_range(31));
        run_transfer(rnd8(), rbit(), len,
                     ($urandom_range(3) == 0) ? int'($urandom_range(5)) : NO_NAK,
                     ($urandom_range(2) == 0) ? int'($urandom_range(1, 3)) : 0, 5);
        repeat ($urandom_range(3))
            send_item($urandom_range(1) ? FUNC_TICK : FUNC_NONE, rbit(), rnd8(), rbit(),
                      5'($urandom), rnd8());
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int budget);
        int stop_at;
        set_config(7'($urandom_range(127)),
                   $urandom_range(1) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(1, 255)));
        idle_pct  = idle;
        stall_pct = stall;
        stop_at   = items_sent + budget;
        while (items_sent < stop_at) random_transfer();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_buffered_write();
        test_long_read();
        test_zero_ack_limit();
        test_late_nak();
        test_stray_items();

        test_random_traffic(0, 0, 260);
        test_random_traffic(72, 0, 260);
        test_random_traffic(0, 72, 260);
        test_random_traffic(13, 13, 270);

        s_tvalid <= 1'b0;
        while (bus_result_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ i2c_master_register_access_core.f @@
rtl/i2cm_pkg.sv
rtl/i2c_master_register_access_core.sv
sim/tb_i2c_master_register_access_core.sv
